// ----- hdl/batc_pkg.sv -----
// Shared constants and types for the bridge/amplifier trim calibrator.
package batc_pkg;

  // Field widths
  localparam int ADC_W    = 10;
  localparam int WIPER_W  = 8;
  localparam int ACT_W    = 5;
  localparam int CHAN_W   = 4;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Default channel count
  localparam int DEF_CHANNELS = 16;

  // Wiper end stop
  localparam logic [WIPER_W-1:0] WIPER_MAX = 8'd255;
  localparam logic [WIPER_W-1:0] WIPER_MIN = 8'd0;

  // Register reset values
  localparam logic [ADC_W-1:0]   RST_TARGET    = 10'd512;
  localparam logic [ADC_W-1:0]   RST_TOLERANCE = 10'd10;
  localparam logic [WIPER_W-1:0] RST_START_POS = 8'd128;
  localparam logic [ACT_W-1:0]   RST_ACTIVE    = 5'd16;

  // Phase codes on the result port
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BRIDGE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_AMP    = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIDGE_TARGET    = 3'd0,
    CFG_BRIDGE_TOLERANCE = 3'd1,
    CFG_AMP_TARGET       = 3'd2,
    CFG_AMP_TOLERANCE    = 3'd3,
    CFG_BRIDGE_START_POS = 3'd4,
    CFG_AMP_START_POS    = 3'd5,
    CFG_ACTIVE_CHANNELS  = 3'd6
  } cfg_idx_t;

  // Calibration sequencer state, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_BRIDGE = 3'b010,
    ST_AMP    = 3'b100
  } state_t;

endpackage

// ----- hdl/bridge_amp_trim_calibrator.sv -----
// Top level: two-wiper trim sequencer with per-channel position stores.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | in_start_req, in_sample
//  out     | out_valid/out_ready| out_channel, out_phase, out_amp_wiper,
//          |                    | out_bridge_wiper, out_settled,
//          |                    | out_out_of_range, out_pass_done
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (write only)
//
// One transaction in gives one transaction out, registered in the next cycle, every cycle while no result is held.
// Band compare and one-count wiper step sit between the state and result
// registers; the position stores are read a cycle ahead of the step.
// in_ready falls only while a result is held and out_ready is low.
// cfg_ready is always high. Reset is synchronous; per-entry valid bits make
// the stores read as the preset values, with no clearing pass.
module bridge_amp_trim_calibrator #(
  parameter int CHANNELS = batc_pkg::DEF_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Sample channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_req,
  input  logic [batc_pkg::ADC_W-1:0]        in_sample,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [batc_pkg::CHAN_W-1:0]       out_channel,
  output logic [batc_pkg::PHASE_W-1:0]      out_phase,
  output logic [batc_pkg::WIPER_W-1:0]      out_amp_wiper,
  output logic [batc_pkg::WIPER_W-1:0]      out_bridge_wiper,
  output logic                              out_settled,
  output logic                              out_out_of_range,
  output logic                              out_pass_done,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [batc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [batc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = (CH_W + 1 > batc_pkg::ACT_W) ? CH_W + 1 : batc_pkg::ACT_W;
  localparam int AW    = batc_pkg::ADC_W;
  localparam int WW    = batc_pkg::WIPER_W;
  localparam logic [CH_W-1:0]  CH_LAST   = CH_W'(CHANNELS - 1);
  localparam logic [CMP_W-1:0] CH_COUNT  = CMP_W'(CHANNELS);

  // Configuration registers
  logic [AW-1:0]               br_target_r, br_tol_r, amp_target_r, amp_tol_r;
  logic [WW-1:0]               br_start_r, amp_start_r;
  logic [batc_pkg::ACT_W-1:0]  active_r;

  // Sequencer state
  batc_pkg::state_t            state_r, state_nxt;
  logic [CH_W-1:0]             ch_r, ch_nxt;
  logic [WW-1:0]               trial_r, trial_nxt;
  logic [WW-1:0]               br_hold_r, br_hold_nxt;
  logic [WW-1:0]               bridge0_r, bridge0_nxt;
  logic [WW-1:0]               idle_amp_r, idle_amp_nxt;
  logic [WW-1:0]               idle_br_r, idle_br_nxt;

  // Position stores
  logic [WW-1:0]               br_mem  [CHANNELS];
  logic [WW-1:0]               amp_mem [CHANNELS];
  logic [CHANNELS-1:0]         br_vld_r, amp_vld_r;
  logic [WW-1:0]               br_rd_r, amp_rd_r;
  logic                        br_rd_vld_r, amp_rd_vld_r;
  logic [CH_W-1:0]             br_raddr;
  logic                        br_we, amp_we;
  logic [WW-1:0]               br_rd_eff, amp_rd_eff;

  // Output register
  logic                        out_valid_r;
  logic [batc_pkg::CHAN_W-1:0] out_channel_r;
  logic [batc_pkg::PHASE_W-1:0] out_phase_r;
  logic [WW-1:0]               out_amp_r, out_br_r;
  logic                        out_settled_r, out_oor_r, out_done_r;

  // Step datapath
  logic                        in_acc, cfg_we;
  logic [AW:0]                 tgt_x, tol_x, smp_x;
  logic                        below, above, step_up, step_dn, oor_hit, settle;
  logic [WW-1:0]               trial_step;
  logic [CMP_W-1:0]            ch_inc;
  logic                        more_ch;
  logic                        settled_c, oor_c, done_c;
  logic [batc_pkg::PHASE_W-1:0] phase_c;
  logic [WW-1:0]               amp_w_c, br_w_c;
  logic [CMP_W-1:0]            ch_nxt_x;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_target_r  <= batc_pkg::RST_TARGET;
      br_tol_r     <= batc_pkg::RST_TOLERANCE;
      amp_target_r <= batc_pkg::RST_TARGET;
      amp_tol_r    <= batc_pkg::RST_TOLERANCE;
      br_start_r   <= batc_pkg::RST_START_POS;
      amp_start_r  <= batc_pkg::RST_START_POS;
      active_r     <= batc_pkg::RST_ACTIVE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        batc_pkg::CFG_BRIDGE_TARGET:    br_target_r  <= cfg_data[AW-1:0];
        batc_pkg::CFG_BRIDGE_TOLERANCE: br_tol_r     <= cfg_data[AW-1:0];
        batc_pkg::CFG_AMP_TARGET:       amp_target_r <= cfg_data[AW-1:0];
        batc_pkg::CFG_AMP_TOLERANCE:    amp_tol_r    <= cfg_data[AW-1:0];
        batc_pkg::CFG_BRIDGE_START_POS: br_start_r   <= cfg_data[WW-1:0];
        batc_pkg::CFG_AMP_START_POS:    amp_start_r  <= cfg_data[WW-1:0];
        batc_pkg::CFG_ACTIVE_CHANNELS:  active_r     <= cfg_data[batc_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Band compare, no wrap below zero
  always_comb begin
    if (state_r == batc_pkg::ST_AMP) begin
      tgt_x = {1'b0, amp_target_r};
      tol_x = {1'b0, amp_tol_r};
    end else begin
      tgt_x = {1'b0, br_target_r};
      tol_x = {1'b0, br_tol_r};
    end
    smp_x = {1'b0, in_sample};
  end

  assign below   = (smp_x + tol_x) < tgt_x;
  assign above   = smp_x > (tgt_x + tol_x);
  assign step_up = (state_r == batc_pkg::ST_BRIDGE) ? below : above;
  assign step_dn = (state_r == batc_pkg::ST_BRIDGE) ? above : below;

  // One-count wiper step with clamp at the end stops
  always_comb begin
    trial_step = trial_r;
    oor_hit    = 1'b0;
    if (step_up) begin
      if (trial_r == batc_pkg::WIPER_MAX) oor_hit = 1'b1;
      else trial_step = trial_r + 1'b1;
    end else if (step_dn) begin
      if (trial_r == batc_pkg::WIPER_MIN) oor_hit = 1'b1;
      else trial_step = trial_r - 1'b1;
    end
  end

  assign settle  = oor_hit || (!step_up && !step_dn);
  assign ch_inc  = CMP_W'(ch_r) + 1'b1;
  assign more_ch = (ch_inc < CMP_W'(active_r)) && (ch_inc < CH_COUNT);

  // Store read data, unwritten entries read as the preset
  assign br_rd_eff  = br_rd_vld_r  ? br_rd_r  : br_start_r;
  assign amp_rd_eff = amp_rd_vld_r ? amp_rd_r : amp_start_r;

  // Next-state logic
  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    trial_nxt    = trial_r;
    br_hold_nxt  = br_hold_r;
    bridge0_nxt  = bridge0_r;
    idle_amp_nxt = idle_amp_r;
    idle_br_nxt  = idle_br_r;
    settled_c    = 1'b0;
    oor_c        = 1'b0;
    done_c       = 1'b0;
    br_we        = 1'b0;
    amp_we       = 1'b0;
    if (in_acc) begin
      priority if (in_start_req) begin
        state_nxt = batc_pkg::ST_BRIDGE;
        ch_nxt    = '0;
        trial_nxt = bridge0_r;
      end else if (state_r == batc_pkg::ST_BRIDGE) begin
        trial_nxt = trial_step;
        settled_c = settle;
        oor_c     = oor_hit;
        if (settle) begin
          br_we       = 1'b1;
          br_hold_nxt = trial_step;
          if (ch_r == '0) bridge0_nxt = trial_step;
          state_nxt   = batc_pkg::ST_AMP;
          trial_nxt   = amp_rd_eff;
        end
      end else if (state_r == batc_pkg::ST_AMP) begin
        trial_nxt = trial_step;
        settled_c = settle;
        oor_c     = oor_hit;
        if (settle) begin
          amp_we = 1'b1;
          if (more_ch) begin
            ch_nxt    = ch_inc[CH_W-1:0];
            state_nxt = batc_pkg::ST_BRIDGE;
            trial_nxt = br_rd_eff;
          end else begin
            state_nxt    = batc_pkg::ST_IDLE;
            done_c       = 1'b1;
            idle_amp_nxt = trial_step;
            idle_br_nxt  = br_hold_r;
          end
        end
      end else begin
        state_nxt = batc_pkg::ST_IDLE;
      end
    end
    // Preset writes reload the stores, so the held and idle views follow them
    if (cfg_we && cfg_index == batc_pkg::CFG_BRIDGE_START_POS) begin
      bridge0_nxt = cfg_data[WW-1:0];
      br_hold_nxt = cfg_data[WW-1:0];
      idle_br_nxt = cfg_data[WW-1:0];
    end
    if (cfg_we && cfg_index == batc_pkg::CFG_AMP_START_POS) begin
      idle_amp_nxt = cfg_data[WW-1:0];
    end
  end

  // Wiper view after the step
  always_comb begin
    unique case (state_nxt)
      batc_pkg::ST_BRIDGE: begin
        phase_c = batc_pkg::PH_BRIDGE;
        amp_w_c = batc_pkg::WIPER_MAX;
        br_w_c  = trial_nxt;
      end
      batc_pkg::ST_AMP: begin
        phase_c = batc_pkg::PH_AMP;
        amp_w_c = trial_nxt;
        br_w_c  = br_hold_nxt;
      end
      default: begin
        phase_c = batc_pkg::PH_IDLE;
        amp_w_c = idle_amp_nxt;
        br_w_c  = idle_br_nxt;
      end
    endcase
  end

  assign ch_nxt_x = CMP_W'(ch_nxt);
  // Bridge store is read ahead at the following channel
  assign br_raddr = (ch_nxt == CH_LAST) ? '0 : CH_W'(ch_nxt + 1'b1);

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= batc_pkg::ST_IDLE;
      ch_r       <= '0;
      trial_r    <= '0;
      br_hold_r  <= batc_pkg::RST_START_POS;
      bridge0_r  <= batc_pkg::RST_START_POS;
      idle_amp_r <= batc_pkg::RST_START_POS;
      idle_br_r  <= batc_pkg::RST_START_POS;
    end else begin
      state_r    <= state_nxt;
      ch_r       <= ch_nxt;
      trial_r    <= trial_nxt;
      br_hold_r  <= br_hold_nxt;
      bridge0_r  <= bridge0_nxt;
      idle_amp_r <= idle_amp_nxt;
      idle_br_r  <= idle_br_nxt;
    end
  end

  // Valid bits of the position stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_vld_r  <= '0;
      amp_vld_r <= '0;
    end else begin
      if (cfg_we && cfg_index == batc_pkg::CFG_BRIDGE_START_POS) br_vld_r <= '0;
      else if (br_we) br_vld_r[ch_r] <= 1'b1;
      if (cfg_we && cfg_index == batc_pkg::CFG_AMP_START_POS) amp_vld_r <= '0;
      else if (amp_we) amp_vld_r[ch_r] <= 1'b1;
    end
  end

  // Position stores: one write, one registered read each; a preset write
  // drops the read valid in the same cycle
  always_ff @(posedge clk) begin
    if (br_we) br_mem[ch_r] <= trial_step;
    br_rd_r     <= br_mem[br_raddr];
    br_rd_vld_r <= br_vld_r[br_raddr] &&
                   !(cfg_we && cfg_index == batc_pkg::CFG_BRIDGE_START_POS);
  end

  always_ff @(posedge clk) begin
    if (amp_we) amp_mem[ch_r] <= trial_step;
    amp_rd_r     <= amp_mem[ch_nxt];
    amp_rd_vld_r <= amp_vld_r[ch_nxt] &&
                    !(cfg_we && cfg_index == batc_pkg::CFG_AMP_START_POS);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_channel_r <= ch_nxt_x[batc_pkg::CHAN_W-1:0];
      out_phase_r   <= phase_c;
      out_amp_r     <= amp_w_c;
      out_br_r      <= br_w_c;
      out_settled_r <= settled_c;
      out_oor_r     <= oor_c;
      out_done_r    <= done_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_phase        = out_phase_r;
  assign out_amp_wiper    = out_amp_r;
  assign out_bridge_wiper = out_br_r;
  assign out_settled      = out_settled_r;
  assign out_out_of_range = out_oor_r;
  assign out_pass_done    = out_done_r;

  // Checks
  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample gave no result");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pass_done |-> out_phase == batc_pkg::PH_IDLE && out_settled)
    else $error("pass done without settling to idle");

  a_oor_settled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_settled)
    else $error("out of range flag without settle");

  a_bridge_amp_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == batc_pkg::PH_BRIDGE |-> out_amp_wiper == batc_pkg::WIPER_MAX)
    else $error("amp wiper not at end stop during bridge trim");

  a_start_ch0: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_start_req |=> out_channel == '0 &&
      out_phase == batc_pkg::PH_BRIDGE)
    else $error("start did not restart at channel zero");

endmodule
